### rtl/core/aeb_pkg.sv
package aeb_pkg;

    // Curvature factor limits, Q16.
    localparam logic [16:0] COMP_ONE   = 17'd65536;
    localparam logic [16:0] COMP_MAX   = 17'd85197;
    // Rounding offset for the Q16 product of safe distance and factor.
    localparam logic [33:0] SD_ROUND   = 34'd32768;
    // Minimum gap between safe distance and hard floor, Q10.6.
    localparam logic [16:0] MIN_GAP    = 17'd64;
    // ceil(2^20 / 5), exact for dividends below 2^18.
    localparam logic [17:0] RECIP5     = 18'd209716;
    // ceil(2^20 / 3), exact for dividends below 2^19.
    localparam logic [18:0] RECIP3     = 19'd349526;
    // Unity ratio in Q16.
    localparam logic [16:0] RATIO_ONE  = 17'd65536;
    // Closing speed excess at which the speed ratio saturates.
    localparam logic [15:0] SR_SAT_D   = 16'd615;
    // Rounding offset before the final 32-bit shift of the ramp.
    localparam logic [45:0] RAMP_ROUND = 46'h0_8000_0000;
    // Divider depth: one quotient bit per stage.
    localparam int unsigned DIV_BITS   = 16;

    typedef enum logic [2:0] {
        REG_MIN_CLOSING = 3'd0,
        REG_SOFT_BUFFER = 3'd1,
        REG_FLOOR       = 3'd2,
        REG_FALLBACK    = 3'd3,
        REG_MAX_AEB     = 3'd4,
        REG_MAX_LON     = 3'd5,
        REG_MAX_DRIVE   = 3'd6
    } reg_addr_t;

    typedef struct packed {
        logic [9:0]  min_closing_speed;
        logic [11:0] soft_buffer;
        logic [11:0] full_brake_floor;
        logic [11:0] fallback_safe_dist;
        logic [11:0] max_aeb_decel;
        logic [11:0] max_lon_brake;
        logic [11:0] max_drive_accel;
    } cfg_t;

    typedef struct packed {
        logic [15:0]        lead_distance;
        logic [15:0]        host_speed;
        logic [15:0]        target_speed;
        logic [15:0]        safe_distance;
        logic               safe_distance_valid;
        logic signed [15:0] curvature;
        logic signed [11:0] longitudinal_request;
        logic               source_fresh;
    } meas_t;

    // Per-item control carried alongside the ratio divider.
    typedef struct packed {
        logic               stale;
        logic               full;
        logic               ramp_en;
        logic               in_sd;
        logic [16:0]        sr;
        logic signed [12:0] req;
    } side_t;

endpackage

### rtl/core/aeb_if.sv
interface aeb_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        lead_distance;
    logic [15:0]        host_speed;
    logic [15:0]        target_speed;
    logic [15:0]        safe_distance;
    logic               safe_distance_valid;
    logic signed [15:0] curvature;
    logic signed [11:0] longitudinal_request;
    logic               source_fresh;

    modport source (
        output valid, lead_distance, host_speed, target_speed, safe_distance,
               safe_distance_valid, curvature, longitudinal_request, source_fresh,
        input  ready
    );
    modport sink (
        input  valid, lead_distance, host_speed, target_speed, safe_distance,
               safe_distance_valid, curvature, longitudinal_request, source_fresh,
        output ready
    );
endinterface

interface aeb_out_if;
    logic               valid;
    logic               ready;
    logic signed [12:0] brake_cmd;
    logic               aeb_active;
    logic               full_brake;

    modport source (
        output valid, brake_cmd, aeb_active, full_brake,
        input  ready
    );
    modport sink (
        input  valid, brake_cmd, aeb_active, full_brake,
        output ready
    );
endinterface

### rtl/core/aeb_front.sv
module aeb_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  aeb_pkg::cfg_t cfg,
    input  logic          in_valid,
    input  aeb_pkg::meas_t meas,
    output logic          out_valid,
    output logic [16:0]   num,
    output logic [16:0]   den,
    output aeb_pkg::side_t side
);
    import aeb_pkg::*;

    // Stage 1: curvature factor, base distance, closing speed, request clamp.
    logic signed [16:0] cext;
    logic [16:0]        acurv;
    logic [18:0]        comp_raw;
    logic [16:0]        comp_c;
    logic [15:0]        base_c;
    logic [15:0]        closing;
    logic [15:0]        dexc;
    logic signed [13:0] req_x;
    logic signed [13:0] neg_drive;
    logic signed [13:0] lon_x;
    logic signed [12:0] req_c;

    always_comb
    begin
        cext      = 17'(meas.curvature);
        acurv     = (cext < 0) ? 17'(-cext) : 17'(cext);
        comp_raw  = 19'(COMP_ONE) + 19'(acurv) * 19'd3;
        comp_c    = (comp_raw > 19'(COMP_MAX)) ? COMP_MAX : comp_raw[16:0];
        base_c    = (meas.safe_distance_valid && meas.safe_distance != 16'd0)
                    ? meas.safe_distance : 16'(cfg.fallback_safe_dist);
        closing   = (meas.host_speed > meas.target_speed)
                    ? meas.host_speed - meas.target_speed : 16'd0;
        dexc      = closing - 16'(cfg.min_closing_speed);
        req_x     = 14'(meas.longitudinal_request);
        neg_drive = -$signed({2'b00, cfg.max_drive_accel});
        lon_x     = $signed({2'b00, cfg.max_lon_brake});
        if (req_x < neg_drive)
        begin
            req_c = 13'(neg_drive);
        end
        else if (req_x > lon_x)
        begin
            req_c = 13'(lon_x);
        end
        else
        begin
            req_c = 13'(req_x);
        end
    end

    logic               v1_reg;
    logic [15:0]        dist1_reg;
    logic [15:0]        base1_reg;
    logic [16:0]        comp1_reg;
    logic               spd1_reg;
    logic               dsat1_reg;
    logic [18:0]        x1_reg;
    logic signed [12:0] req1_reg;
    logic               stale1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist1_reg  <= meas.lead_distance;
            base1_reg  <= base_c;
            comp1_reg  <= comp_c;
            spd1_reg   <= (closing >= 16'(cfg.min_closing_speed));
            dsat1_reg  <= (dexc >= SR_SAT_D);
            x1_reg     <= 19'(dexc[9:0]) * 19'd320;
            req1_reg   <= req_c;
            stale1_reg <= !meas.source_fresh;
        end
    end

    // Stage 2: scaled safe distance and speed ratio.
    logic [33:0] sd_prod;
    logic [37:0] sr_prod;
    logic [16:0] sr_c;

    always_comb
    begin
        sd_prod = 34'(base1_reg) * 34'(comp1_reg) + SD_ROUND;
        sr_prod = 38'(x1_reg) * 38'(RECIP3);
        sr_c    = dsat1_reg ? RATIO_ONE : sr_prod[36:20];
    end

    logic               v2_reg;
    logic [15:0]        dist2_reg;
    logic [16:0]        sd2_reg;
    logic [16:0]        sr2_reg;
    logic               spd2_reg;
    logic signed [12:0] req2_reg;
    logic               stale2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist2_reg  <= dist1_reg;
            sd2_reg    <= sd_prod[32:16];
            sr2_reg    <= sr_c;
            spd2_reg   <= spd1_reg;
            req2_reg   <= req1_reg;
            stale2_reg <= stale1_reg;
        end
    end

    // Stage 3: soft band edge, two fifths of the safe distance, gap limit.
    logic [16:0] flr17;
    logic [17:0] two_sd;
    logic [35:0] fifth_prod;
    logic [16:0] sdm;
    logic [16:0] lowcap;

    always_comb
    begin
        flr17      = 17'(cfg.full_brake_floor);
        two_sd     = {sd2_reg, 1'b0} + 18'd2;
        fifth_prod = 36'(two_sd) * 36'(RECIP5);
        sdm        = (sd2_reg >= MIN_GAP) ? sd2_reg - MIN_GAP : 17'd0;
        lowcap     = (sdm > flr17) ? sdm : flr17;
    end

    logic               v3_reg;
    logic [15:0]        dist3_reg;
    logic [16:0]        sd3_reg;
    logic [16:0]        soft3_reg;
    logic [15:0]        q5_3_reg;
    logic [16:0]        lowcap3_reg;
    logic [16:0]        sr3_reg;
    logic               spd3_reg;
    logic signed [12:0] req3_reg;
    logic               stale3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist3_reg   <= dist2_reg;
            sd3_reg     <= sd2_reg;
            soft3_reg   <= sd2_reg + 17'(cfg.soft_buffer);
            q5_3_reg    <= fifth_prod[35:20];
            lowcap3_reg <= lowcap;
            sr3_reg     <= sr2_reg;
            spd3_reg    <= spd2_reg;
            req3_reg    <= req2_reg;
            stale3_reg  <= stale2_reg;
        end
    end

    // Stage 4: hard floor, band decision and ramp operands.
    logic [16:0] hi;
    logic [16:0] hf;
    logic [16:0] dist17;
    logic        full_c;
    logic        in_sd_c;
    side_t       side_c;

    always_comb
    begin
        hi      = (17'(q5_3_reg) > flr17) ? 17'(q5_3_reg) : flr17;
        hf      = (hi < lowcap3_reg) ? hi : lowcap3_reg;
        dist17  = 17'(dist3_reg);
        full_c  = (dist3_reg != 16'd0) && (dist17 <= hf);
        in_sd_c = (dist17 < sd3_reg);
        side_c.stale   = stale3_reg;
        side_c.full    = full_c;
        side_c.ramp_en = (dist3_reg != 16'd0) && !full_c && spd3_reg
                         && (dist17 < soft3_reg);
        side_c.in_sd   = in_sd_c;
        side_c.sr      = sr3_reg;
        side_c.req     = req3_reg;
    end

    logic        v4_reg;
    logic [16:0] num4_reg;
    logic [16:0] den4_reg;
    side_t       side4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num4_reg  <= in_sd_c ? sd3_reg - dist17 : soft3_reg - dist17;
            den4_reg  <= in_sd_c ? sd3_reg - hf : soft3_reg - sd3_reg;
            side4_reg <= side_c;
        end
    end

    assign out_valid = v4_reg;
    assign num       = num4_reg;
    assign den       = den4_reg;
    assign side      = side4_reg;

endmodule

### rtl/core/aeb_div.sv
module aeb_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  logic [16:0]    num,
    input  logic [16:0]    den,
    input  aeb_pkg::side_t in_side,
    output logic           out_valid,
    output logic [16:0]    ratio,
    output aeb_pkg::side_t out_side
);
    import aeb_pkg::*;

    // Restoring divider, one quotient bit per stage. A numerator at or above
    // the denominator, or a zero denominator, saturates the ratio to one.
    logic        v_reg    [1:DIV_BITS];
    logic [16:0] rem_reg  [1:DIV_BITS];
    logic [16:0] den_reg  [1:DIV_BITS];
    logic [15:0] q_reg    [1:DIV_BITS];
    logic        sat_reg  [1:DIV_BITS];
    side_t       side_reg [1:DIV_BITS];

    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_stage
        logic        v_src;
        logic [16:0] rem_src;
        logic [16:0] den_src;
        logic [15:0] q_src;
        logic        sat_src;
        side_t       side_src;
        logic [17:0] shifted;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign v_src    = in_valid;
            assign rem_src  = num;
            assign den_src  = den;
            assign q_src    = 16'd0;
            assign sat_src  = (den == 17'd0) || (num >= den);
            assign side_src = in_side;
        end
        else
        begin : g_next
            assign v_src    = v_reg[k];
            assign rem_src  = rem_reg[k];
            assign den_src  = den_reg[k];
            assign q_src    = q_reg[k];
            assign sat_src  = sat_reg[k];
            assign side_src = side_reg[k];
        end

        assign shifted = {rem_src, 1'b0};
        assign ge      = (shifted >= 18'(den_src));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k+1] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1]  <= ge ? 17'(shifted - 18'(den_src)) : shifted[16:0];
                den_reg[k+1]  <= den_src;
                q_reg[k+1]    <= {q_src[14:0], ge};
                sat_reg[k+1]  <= sat_src;
                side_reg[k+1] <= side_src;
            end
        end
    end

    assign out_valid = v_reg[DIV_BITS];
    assign ratio     = sat_reg[DIV_BITS] ? RATIO_ONE : 17'(q_reg[DIV_BITS]);
    assign out_side  = side_reg[DIV_BITS];

endmodule

### rtl/core/aeb_ramp.sv
module aeb_ramp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  aeb_pkg::cfg_t      cfg,
    input  logic               in_valid,
    input  logic [16:0]        ratio,
    input  aeb_pkg::side_t     in_side,
    output logic               out_valid,
    output logic signed [12:0] brake_cmd,
    output logic               aeb_active,
    output logic               full_brake
);
    import aeb_pkg::*;

    // Stage 1: speed ratio times distance ratio.
    logic        v1_reg;
    logic [32:0] t1_reg;
    logic [16:0] r1_reg;
    side_t       side1_reg;
    logic [33:0] t1_prod;

    assign t1_prod = 34'(in_side.sr) * 34'(ratio);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg    <= t1_prod[32:0];
            r1_reg    <= ratio;
            side1_reg <= in_side;
        end
    end

    // Stage 2: second ratio factor, back to Q32.
    logic        v2_reg;
    logic [32:0] t2_reg;
    side_t       side2_reg;
    logic [49:0] t2_prod;

    assign t2_prod = 50'(t1_reg) * 50'(r1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t2_reg    <= t2_prod[48:16];
            side2_reg <= side1_reg;
        end
    end

    // Stage 3: scale by the band's peak deceleration and round.
    logic        v3_reg;
    logic [12:0] aeb3_reg;
    side_t       side3_reg;
    logic [11:0] peak;
    logic [44:0] t3_prod;
    logic [45:0] t3_round;
    logic [12:0] aeb_c;

    always_comb
    begin
        peak     = side2_reg.in_sd ? cfg.max_aeb_decel : cfg.max_lon_brake;
        t3_prod  = 45'(t2_reg) * 45'(peak);
        t3_round = 46'(t3_prod) + RAMP_ROUND;
        if (side2_reg.full)
        begin
            aeb_c = 13'(cfg.max_aeb_decel);
        end
        else if (side2_reg.ramp_en)
        begin
            aeb_c = t3_round[44:32];
        end
        else
        begin
            aeb_c = 13'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            aeb3_reg  <= aeb_c;
            side3_reg <= side2_reg;
        end
    end

    // Stage 4: merge with the request, final clamp, stale-source override, output register.
    logic signed [13:0] aeb_x;
    logic signed [13:0] req_x;
    logic signed [13:0] req_pos;
    logic signed [13:0] merged;
    logic signed [13:0] neg_drive;
    logic signed [13:0] max_aeb_x;
    logic signed [13:0] br;

    always_comb
    begin
        aeb_x     = $signed({1'b0, aeb3_reg});
        req_x     = 14'(side3_reg.req);
        req_pos   = (req_x > 14'sd0) ? req_x : 14'sd0;
        neg_drive = -$signed({2'b00, cfg.max_drive_accel});
        max_aeb_x = $signed({2'b00, cfg.max_aeb_decel});
        if (aeb3_reg != 13'd0)
        begin
            merged = (aeb_x > req_pos) ? aeb_x : req_pos;
        end
        else
        begin
            merged = req_x;
        end
        if (merged < neg_drive)
        begin
            br = neg_drive;
        end
        else if (merged > max_aeb_x)
        begin
            br = max_aeb_x;
        end
        else
        begin
            br = merged;
        end
    end

    logic               v4_reg;
    logic signed [12:0] cmd4_reg;
    logic               act4_reg;
    logic               full4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (side3_reg.stale)
            begin
                cmd4_reg  <= $signed({1'b0, cfg.max_aeb_decel});
                act4_reg  <= 1'b0;
                full4_reg <= 1'b1;
            end
            else
            begin
                cmd4_reg  <= 13'(br);
                act4_reg  <= (aeb3_reg != 13'd0);
                full4_reg <= side3_reg.full;
            end
        end
    end

    assign out_valid  = v4_reg;
    assign brake_cmd  = cmd4_reg;
    assign aeb_active = act4_reg;
    assign full_brake = full4_reg;

endmodule

### rtl/core/aeb_brake_command_top.sv
// Emergency brake command block.
// Input channel meas carries one measurement set per transaction: lead
// distance, ego and lead speed, safe distance with its valid flag, road
// curvature, the requested longitudinal command and the source freshness flag.
// Output channel cmd carries one transaction per input: the final command,
// the emergency-active flag and the full-brake flag.
// The seven tuning registers sit on the APB port at byte addresses 0 to 24; they
// must be written only while the pipeline is empty; the block does not enforce it.
// The path from input transaction to output valid runs through four stages of
// geometry, a sixteen-stage ratio divider that yields one quotient bit per
// stage, and four stages of ramp multiply and merge. Throughput is one
// transaction per cycle while the receiver does not stall.
// Reset clears all stage valid bits and loads the registers with their
// default tuning; no clearing pass is needed.
// When the receiver stalls, the whole pipeline holds and meas.ready drops in
// the same cycle; the finished result waits in the output register.
module aeb_brake_command_top (
    input  logic         clk,
    input  logic         rst_n,
    aeb_in_if.sink       meas,
    aeb_out_if.source    cmd,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import aeb_pkg::*;

    // Configuration registers.
    cfg_t      cfg_reg;
    reg_addr_t addr;

    assign addr   = reg_addr_t'(paddr[4:2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_closing_speed  <= 10'd154;
            cfg_reg.soft_buffer        <= 12'd192;
            cfg_reg.full_brake_floor   <= 12'd160;
            cfg_reg.fallback_safe_dist <= 12'd320;
            cfg_reg.max_aeb_decel      <= 12'd2557;
            cfg_reg.max_lon_brake      <= 12'd1536;
            cfg_reg.max_drive_accel    <= 12'd1536;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (addr)
                REG_MIN_CLOSING: cfg_reg.min_closing_speed  <= pwdata[9:0];
                REG_SOFT_BUFFER: cfg_reg.soft_buffer        <= pwdata[11:0];
                REG_FLOOR:       cfg_reg.full_brake_floor   <= pwdata[11:0];
                REG_FALLBACK:    cfg_reg.fallback_safe_dist <= pwdata[11:0];
                REG_MAX_AEB:     cfg_reg.max_aeb_decel      <= pwdata[11:0];
                REG_MAX_LON:     cfg_reg.max_lon_brake      <= pwdata[11:0];
                REG_MAX_DRIVE:   cfg_reg.max_drive_accel    <= pwdata[11:0];
                default:         ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (addr)
            REG_MIN_CLOSING: prdata = 32'(cfg_reg.min_closing_speed);
            REG_SOFT_BUFFER: prdata = 32'(cfg_reg.soft_buffer);
            REG_FLOOR:       prdata = 32'(cfg_reg.full_brake_floor);
            REG_FALLBACK:    prdata = 32'(cfg_reg.fallback_safe_dist);
            REG_MAX_AEB:     prdata = 32'(cfg_reg.max_aeb_decel);
            REG_MAX_LON:     prdata = 32'(cfg_reg.max_lon_brake);
            REG_MAX_DRIVE:   prdata = 32'(cfg_reg.max_drive_accel);
            default:         prdata = 32'd0;
        endcase
    end

    // Global pipeline advance: move whenever the output register is empty or its result is taken.
    logic adv;
    logic out_valid;

    assign adv        = !out_valid || cmd.ready;
    assign meas.ready = adv;
    assign cmd.valid  = out_valid;

    meas_t m;

    always_comb
    begin
        m.lead_distance        = meas.lead_distance;
        m.host_speed           = meas.host_speed;
        m.target_speed         = meas.target_speed;
        m.safe_distance        = meas.safe_distance;
        m.safe_distance_valid  = meas.safe_distance_valid;
        m.curvature            = meas.curvature;
        m.longitudinal_request = meas.longitudinal_request;
        m.source_fresh         = meas.source_fresh;
    end

    logic        f_valid;
    logic [16:0] f_num;
    logic [16:0] f_den;
    side_t       f_side;

    aeb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg_reg),
        .in_valid  (meas.valid),
        .meas      (m),
        .out_valid (f_valid),
        .num       (f_num),
        .den       (f_den),
        .side      (f_side)
    );

    logic        d_valid;
    logic [16:0] d_ratio;
    side_t       d_side;

    aeb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .num       (f_num),
        .den       (f_den),
        .in_side   (f_side),
        .out_valid (d_valid),
        .ratio     (d_ratio),
        .out_side  (d_side)
    );

    aeb_ramp u_ramp (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .cfg        (cfg_reg),
        .in_valid   (d_valid),
        .ratio      (d_ratio),
        .in_side    (d_side),
        .out_valid  (out_valid),
        .brake_cmd  (cmd.brake_cmd),
        .aeb_active (cmd.aeb_active),
        .full_brake (cmd.full_brake)
    );

endmodule
